// ----- sv/tsdf_pkg.sv -----
// package: shared types, codes and constants of the voxel integration block
`default_nettype none
package tsdf_pkg;

  localparam int MAX_WIDTH_DEF  = 640;
  localparam int MAX_HEIGHT_DEF = 480;

  typedef enum logic [2:0] {
    RS_OK      = 3'd0,
    RS_BEHIND  = 3'd1,
    RS_OUTSIDE = 3'd2,
    RS_NODEPTH = 3'd3,
    RS_BAND    = 3'd4,
    RS_FULL    = 3'd5
  } reason_t;

  typedef enum logic [2:0] {
    CFG_FOCAL_X  = 3'd0,
    CFG_FOCAL_Y  = 3'd1,
    CFG_CENTER_X = 3'd2,
    CFG_CENTER_Y = 3'd3,
    CFG_TRUNC    = 3'd4,
    CFG_WCAP     = 3'd5,
    CFG_WIDTH    = 3'd6,
    CFG_HEIGHT   = 3'd7
  } cfg_idx_t;

  localparam logic KIND_DEPTH = 1'b0;
  localparam logic KIND_VOXEL = 1'b1;

  // payload that travels along the pipeline
  typedef struct packed {
    logic               vld;
    logic               kind;
    logic        [18:0] idx;
    logic        [15:0] depth;
    logic signed [15:0] z;
    logic signed [15:0] osdf;
    logic        [7:0]  ow;
    logic               sx;
    reason_t            reason;
    logic        [9:0]  col;
    logic        [8:0]  row;
    logic        [19:0] addr;
    logic               wok;
    logic               se;
    logic signed [16:0] obs;
    logic signed [24:0] prod;
    logic               ss;
  } pl_t;

endpackage
`default_nettype wire

// ----- sv/tsdf_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with a side payload
`default_nettype none
module tsdf_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side_in,
  output logic      [NW-1:0] quo,
  output logic      [SW-1:0] side_out
);

  logic [DW-1:0] rin [NW];
  logic [NW-1:0] ain [NW];
  logic [DW-1:0] din [NW];
  logic [SW-1:0] sin [NW];
  logic [DW-1:0] rr  [NW];
  logic [NW-1:0] ar  [NW];
  logic [DW-1:0] dr  [NW];
  logic [SW-1:0] sr  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0]   t;
    logic          ge;
    logic [DW:0]   diff;

    if (k == 0) begin : g_first
      assign rin[k] = '0;
      assign ain[k] = num;
      assign din[k] = den;
      assign sin[k] = side_in;
    end else begin : g_next
      assign rin[k] = rr[k-1];
      assign ain[k] = ar[k-1];
      assign din[k] = dr[k-1];
      assign sin[k] = sr[k-1];
    end

    assign t    = {rin[k], ain[k][NW-1]};
    assign ge   = t >= {1'b0, din[k]};
    assign diff = t - {1'b0, din[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        rr[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
        ar[k] <= {ain[k][NW-2:0], ge};
        dr[k] <= din[k];
      end
    end

    // side payload carries the valid bit, so it is cleared on reset
    always_ff @(posedge clk) begin
      if (rst) begin
        sr[k] <= '0;
      end else if (en) begin
        sr[k] <= sin[k];
      end
    end
  end

  assign quo      = ar[NW-1];
  assign side_out = sr[NW-1];

endmodule
`default_nettype wire

// ----- sv/tsdf_voxel_integrate_top.sv -----
// top level: depth frame store and pipelined tsdf voxel update
// throughput: one item per cycle while no result item waits on m_tready,
// set by the four pipelined dividers and one store port
// the whole pipeline holds while a result item waits on m_tready
// depth writes and voxel reads share the store port at one stage, so order is kept
// reset: synchronous; clears pipeline valids and loads default settings; store is not cleared
`default_nettype none
module tsdf_voxel_integrate_top #(
  parameter int MAX_WIDTH  = tsdf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = tsdf_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // pixel_index, depth_mm, cam_x, cam_y, cam_z, old_sdf, weight, zero fill
  input  wire logic [111:0] s_tdata,
  // kind
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // updated, skip_reason, new_sdf, weight, zero fill
  output logic      [31:0]  m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import tsdf_pkg::*;

  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(STORE);

  logic [15:0] focal_x, focal_y, center_x, center_y;
  logic [9:0]  trunc_band_mm, image_width;
  logic [7:0]  weight_cap;
  logic [8:0]  image_height;

  logic en;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x <= 16'd8400;
      focal_y <= 16'd8400;
      center_x <= 16'd5112;
      center_y <= 16'd3832;
      trunc_band_mm <= 10'd20;
      weight_cap <= 8'd100;
      image_width <= 10'd640;
      image_height <= 9'd480;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FOCAL_X:  focal_x <= cfg_data;
        CFG_FOCAL_Y:  focal_y <= cfg_data;
        CFG_CENTER_X: center_x <= cfg_data;
        CFG_CENTER_Y: center_y <= cfg_data;
        CFG_TRUNC:    trunc_band_mm <= cfg_data[9:0];
        CFG_WCAP:     weight_cap <= cfg_data[7:0];
        CFG_WIDTH:    image_width <= cfg_data[9:0];
        CFG_HEIGHT:   image_height <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // input register
  pl_t p0, p0_next;
  logic signed [15:0] x0, y0;
  always_comb begin
    p0_next       = '0;
    p0_next.vld   = s_tvalid;
    p0_next.kind  = s_tuser;
    p0_next.idx   = s_tdata[18:0];
    p0_next.depth = s_tdata[34:19];
    p0_next.z     = s_tdata[82:67];
    p0_next.osdf  = s_tdata[98:83];
    p0_next.ow    = s_tdata[106:99];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      p0 <= '0;
    end else if (en) begin
      p0 <= p0_next;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x0 <= s_tdata[50:35];
      y0 <= s_tdata[66:51];
    end
  end

  // projection products
  pl_t p1, p1_next;
  logic [31:0] pxm, pym;
  logic        sy1;
  logic [15:0] ax0, ay0;
  assign ax0 = x0[15] ? 16'(-x0) : x0;
  assign ay0 = y0[15] ? 16'(-y0) : y0;
  always_comb begin
    p1_next        = p0;
    p1_next.sx     = x0[15];
    p1_next.reason = (p0.z <= 16'sd0) ? RS_BEHIND : RS_OK;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= '0;
    end else if (en) begin
      p1 <= p1_next;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      pxm <= 32'(focal_x) * 32'(ax0);
      pym <= 32'(focal_y) * 32'(ay0);
      sy1 <= y0[15];
    end
  end

  logic [31:0]        qu, qv;
  logic [$bits(pl_t)-1:0] side_u;
  logic               syd;
  pl_t                pd1;

  tsdf_div #(.NW(32), .DW(16), .SW($bits(pl_t))) u_div_u (
    .clk(clk), .rst(rst), .en(en), .num(pxm), .den(p1.z), .side_in(p1),
    .quo(qu), .side_out(side_u)
  );
  tsdf_div #(.NW(32), .DW(16), .SW(1)) u_div_v (
    .clk(clk), .rst(rst), .en(en), .num(pym), .den(p1.z), .side_in(sy1),
    .quo(qv), .side_out(syd)
  );
  assign pd1 = pl_t'(side_u);

  // pixel coordinates and border test
  logic signed [34:0] su, sv, u16, v16, ulim, vlim, u8, v8;
  assign su   = pd1.sx ? -$signed({3'b0, qu}) : $signed({3'b0, qu});
  assign sv   = syd    ? -$signed({3'b0, qv}) : $signed({3'b0, qv});
  assign u16  = su + $signed({19'b0, center_x});
  assign v16  = sv + $signed({19'b0, center_y});
  assign ulim = ($signed({25'b0, image_width})  - 35'sd2) * 35'sd16;
  assign vlim = ($signed({26'b0, image_height}) - 35'sd2) * 35'sd16;
  assign u8   = u16 + 35'sd8;
  assign v8   = v16 + 35'sd8;

  pl_t p2, p2_next;
  always_comb begin
    p2_next     = pd1;
    p2_next.col = u8[13:4];
    p2_next.row = v8[12:4];
    if (pd1.reason == RS_OK &&
        (u16 < 35'sd16 || u16 > ulim || v16 < 35'sd16 || v16 > vlim))
      p2_next.reason = RS_OUTSIDE;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      p2 <= '0;
    end else if (en) begin
      p2 <= p2_next;
    end
  end

  // store address
  logic [22:0] addr3;
  assign addr3 = 23'(p2.col) + 23'(p2.row) * 23'(image_width);

  pl_t p3, p3_next;
  always_comb begin
    p3_next      = p2;
    p3_next.addr = addr3[19:0];
    p3_next.wok  = 32'(p2.idx) < 32'(STORE);
    if (p2.reason == RS_OK && 32'(addr3) >= 32'(STORE))
      p3_next.reason = RS_OUTSIDE;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      p3 <= '0;
    end else if (en) begin
      p3 <= p3_next;
    end
  end

  // depth frame store
  logic [15:0] depth_mem [STORE];
  logic [15:0] rd;
  logic [AW-1:0] maddr;
  assign maddr = (p3.kind == KIND_VOXEL) ? AW'(p3.addr) : AW'(p3.idx);

  always_ff @(posedge clk) begin
    if (en) begin
      if (p3.vld && p3.kind == KIND_DEPTH && p3.wok)
        depth_mem[maddr] <= p3.depth;
      rd <= depth_mem[maddr];
    end
  end

  pl_t p4;
  always_ff @(posedge clk) begin
    if (rst) begin
      p4 <= '0;
    end else if (en) begin
      p4 <= p3;
    end
  end

  // signed distance and skip tests
  logic signed [17:0] eta;
  logic        [16:0] aeta;
  assign eta  = $signed({2'b0, rd}) - 18'(p4.z);
  assign aeta = eta[17] ? 17'(-eta) : eta[16:0];

  pl_t p5, p5_next;
  logic [24:0] num2;
  always_comb begin
    p5_next    = p4;
    p5_next.se = eta[17];
    if (p4.reason == RS_OK) begin
      if (rd == 16'd0)
        p5_next.reason = RS_NODEPTH;
      else if (aeta > 17'(trunc_band_mm))
        p5_next.reason = RS_BAND;
      else if (p4.ow == weight_cap)
        p5_next.reason = RS_FULL;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      p5 <= '0;
    end else if (en) begin
      p5 <= p5_next;
    end
  end
  always_ff @(posedge clk) begin
    if (en) num2 <= {aeta[9:0], 15'b0};
  end

  logic [24:0]            q2;
  logic [$bits(pl_t)-1:0] side_2;
  pl_t                    pd2;
  tsdf_div #(.NW(25), .DW(10), .SW($bits(pl_t))) u_div_obs (
    .clk(clk), .rst(rst), .en(en), .num(num2), .den(trunc_band_mm), .side_in(p5),
    .quo(q2), .side_out(side_2)
  );
  assign pd2 = pl_t'(side_2);

  // observation and weighted sum
  logic [16:0] m2;
  assign m2 = (trunc_band_mm == 10'd0) ? 17'd0 :
              (q2 > 25'd32767) ? 17'd32767 : q2[16:0];

  pl_t p6, p6_next;
  always_comb begin
    p6_next      = pd2;
    p6_next.obs  = pd2.se ? -$signed(m2) : $signed(m2);
    p6_next.prod = 25'($signed({1'b0, pd2.ow})) * 25'(pd2.osdf);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      p6 <= '0;
    end else if (en) begin
      p6 <= p6_next;
    end
  end

  logic signed [24:0] sum6;
  assign sum6 = p6.prod + 25'(p6.obs);

  pl_t p7, p7_next;
  logic [23:0] num3;
  logic [8:0]  den3;
  always_comb begin
    p7_next    = p6;
    p7_next.ss = sum6[24];
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      p7 <= '0;
    end else if (en) begin
      p7 <= p7_next;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      num3 <= sum6[24] ? 24'(-sum6) : sum6[23:0];
      den3 <= 9'(p6.ow) + 9'd1;
    end
  end

  logic [23:0]            q3;
  logic [$bits(pl_t)-1:0] side_3;
  pl_t                    pd3;
  tsdf_div #(.NW(24), .DW(9), .SW($bits(pl_t))) u_div_avg (
    .clk(clk), .rst(rst), .en(en), .num(num3), .den(den3), .side_in(p7),
    .quo(q3), .side_out(side_3)
  );
  assign pd3 = pl_t'(side_3);

  // result
  logic        [15:0] m3;
  logic signed [15:0] nsdf;
  logic        [8:0]  nw9;
  logic        [7:0]  nw;
  assign m3   = (q3 > 24'd32767) ? 16'd32767 : q3[15:0];
  assign nsdf = pd3.ss ? -$signed(m3) : $signed(m3);
  assign nw9  = 9'(pd3.ow) + 9'd1;
  assign nw   = (nw9 > 9'(weight_cap)) ? weight_cap : nw9[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= pd3.vld && pd3.kind == KIND_VOXEL;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (pd3.reason == RS_OK)
        m_tdata <= {4'b0, nw, nsdf, pd3.reason, 1'b1};
      else
        m_tdata <= {4'b0, pd3.ow, pd3.osdf, pd3.reason, 1'b0};
    end
  end

endmodule
`default_nettype wire

// ----- bench/tsdf_voxel_integrate_top_test.sv -----
// testbench: random and directed tsdf voxel updates checked against an in-bench predictor
`default_nettype none
module tsdf_voxel_integrate_top_test;
  import tsdf_pkg::*;

  localparam int STORE_SIZE = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic        [7:0]  prior_weight;
    logic signed [15:0] old_sdf;
    logic signed [15:0] cam_z;
    logic signed [15:0] cam_y;
    logic signed [15:0] cam_x;
    logic        [15:0] depth_mm;
    logic        [18:0] pixel_index;
  } voxel_item_t;

  typedef struct packed {
    logic        [7:0]  result_weight;
    logic signed [15:0] new_sdf;
    reason_t            skip_reason;
    logic               updated;
  } voxel_result_t;

  class tsdf_board;
    logic [15:0] regs [8];
    logic [15:0] frame [int];
    voxel_result_t pending [$];
    int errors;

    function new();
      regs = '{16'd8400, 16'd8400, 16'd5112, 16'd3832, 16'd20, 16'd100, 16'd640, 16'd480};
      errors = 0;
    endfunction

    function void configure(cfg_idx_t idx, logic [15:0] val);
      case (idx)
        CFG_TRUNC, CFG_WIDTH: regs[idx] = val & 16'h3ff;
        CFG_WCAP: regs[idx] = val & 16'hff;
        CFG_HEIGHT: regs[idx] = val & 16'h1ff;
        default: regs[idx] = val;
      endcase
    endfunction

    // store address a voxel reads, or -1 when it is skipped before the read
    function longint locate(voxel_item_t it);
      longint z, u, v, col, row, a;
      z = longint'(it.cam_z);
      if (z <= 0) return -1;
      u = (longint'(regs[CFG_FOCAL_X]) * longint'(it.cam_x)) / z + longint'(regs[CFG_CENTER_X]);
      v = (longint'(regs[CFG_FOCAL_Y]) * longint'(it.cam_y)) / z + longint'(regs[CFG_CENTER_Y]);
      if (u < 16 || u > (longint'(regs[CFG_WIDTH]) - 2) * 16 ||
          v < 16 || v > (longint'(regs[CFG_HEIGHT]) - 2) * 16) return -1;
      col = (u + 8) >>> 4;
      row = (v + 8) >>> 4;
      a = col + row * longint'(regs[CFG_WIDTH]);
      if (a >= STORE_SIZE) return -1;
      return a;
    endfunction

    function longint sat_sdf(longint v);
      if (v > 32767) return 32767;
      if (v < -32767) return -32767;
      return v;
    endfunction

    function voxel_result_t integrate(voxel_item_t it);
      voxel_result_t r;
      longint a, d, eta, mu, obs, ow, cap;
      r.updated = 1'b0;
      r.new_sdf = it.old_sdf;
      r.result_weight = it.prior_weight;
      a = locate(it);
      mu = longint'(regs[CFG_TRUNC]);
      ow = longint'(it.prior_weight);
      cap = longint'(regs[CFG_WCAP]);
      if (it.cam_z <= 0) r.skip_reason = RS_BEHIND;
      else if (a < 0) r.skip_reason = RS_OUTSIDE;
      else begin
        d = frame.exists(int'(a)) ? longint'(frame[int'(a)]) : 0;
        eta = d - longint'(it.cam_z);
        if (d == 0) r.skip_reason = RS_NODEPTH;
        else if (eta > mu || -eta > mu) r.skip_reason = RS_BAND;
        else if (ow == cap) r.skip_reason = RS_FULL;
        else begin
          obs = (mu == 0) ? 0 : sat_sdf((eta * 32768) / mu);
          r.skip_reason = RS_OK;
          r.updated = 1'b1;
          r.new_sdf = 16'(sat_sdf((ow * longint'(it.old_sdf) + obs) / (ow + 1)));
          r.result_weight = (ow + 1 > cap) ? cap[7:0] : ow[7:0] + 8'd1;
        end
      end
      return r;
    endfunction

    function void note_input(logic kind, voxel_item_t it);
      if (kind == KIND_DEPTH) begin
        if (it.pixel_index < STORE_SIZE) frame[int'(it.pixel_index)] = it.depth_mm;
      end else pending = {pending, integrate(it)};
    endfunction

    function void check_result(voxel_result_t got);
      voxel_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result item %h", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.updated !== exp_r.updated) begin
        $error("updated: expected %0d actual %0d", exp_r.updated, got.updated);
        errors++;
      end
      if (got.skip_reason !== exp_r.skip_reason) begin
        $error("skip_reason: expected %0d actual %0d", exp_r.skip_reason, got.skip_reason);
        errors++;
      end
      if (got.new_sdf !== exp_r.new_sdf) begin
        $error("new_sdf: expected %0d actual %0d", exp_r.new_sdf, got.new_sdf);
        errors++;
      end
      if (got.result_weight !== exp_r.result_weight) begin
        $error("result_weight: expected %0d actual %0d", exp_r.result_weight,
               got.result_weight);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, s_tuser;
  logic [111:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [31:0] m_tdata;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  tsdf_board board = new();
  int send_idle = 14;
  int recv_idle = 45;
  int sent = 0;
  int cycles = 0;

  tsdf_voxel_integrate_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= recv_idle);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_result(voxel_result_t'(m_tdata[27:0]));
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic drive_item(logic kind, voxel_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {5'b0, it};
    do @(posedge clk); while (!s_tready);
    board.note_input(kind, it);
    sent++;
  endtask

  task automatic write_depth(int idx, int d);
    voxel_item_t it;
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    it = voxel_item_t'(raw[106:0]);
    it.pixel_index = idx[18:0];
    it.depth_mm = d[15:0];
    drive_item(KIND_DEPTH, it);
  endtask

  // loads the pixel the voxel will read when asked or when still unwritten
  task automatic voxel_at(int x, int y, int z, int osdf, int ow, bit wr, int d);
    voxel_item_t it;
    logic [127:0] raw;
    longint a;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    it = voxel_item_t'(raw[106:0]);
    it.cam_x = x[15:0];
    it.cam_y = y[15:0];
    it.cam_z = z[15:0];
    it.old_sdf = osdf[15:0];
    it.prior_weight = ow[7:0];
    a = board.locate(it);
    if (a >= 0 && (wr || !board.frame.exists(int'(a)))) write_depth(int'(a), d);
    drive_item(KIND_VOXEL, it);
  endtask

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  task automatic random_voxel();
    int z, x, y, mu, cap, d, ow, p;
    mu = int'(board.regs[CFG_TRUNC]);
    cap = int'(board.regs[CFG_WCAP]);
    if ($urandom_range(0, 99) < 15) begin
      if ($urandom_range(0, 3) == 0) begin
        write_depth($urandom_range(0, 524287), $urandom_range(0, 65535));
        return;
      end
      voxel_at(clamp16($signed($urandom_range(0, 65535)) - 32768),
               clamp16($signed($urandom_range(0, 65535)) - 32768),
               clamp16($signed($urandom_range(0, 65535)) - 32768),
               $urandom_range(0, 65535) - 32768, $urandom_range(0, 255),
               1'b0, $urandom_range(0, 65535));
      return;
    end
    z = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 32767) : $urandom_range(1, 6000);
    p = $urandom_range(16, (board.regs[CFG_WIDTH] - 2) * 16);
    x = clamp16((longint'(p) - longint'(board.regs[CFG_CENTER_X])) * longint'(z) /
                longint'(board.regs[CFG_FOCAL_X]));
    p = $urandom_range(16, (board.regs[CFG_HEIGHT] - 2) * 16);
    y = clamp16((longint'(p) - longint'(board.regs[CFG_CENTER_Y])) * longint'(z) /
                longint'(board.regs[CFG_FOCAL_Y]));
    d = z + $urandom_range(0, 2 * mu + 6) - mu - 3;
    if (d < 1) d = 1;
    if (d > 65535) d = 65535;
    if ($urandom_range(0, 99) < 8) d = 0;
    case ($urandom_range(0, 9))
      0, 1: ow = cap;
      2: ow = $urandom_range(0, 255);
      default: ow = (cap == 0) ? 0 : $urandom_range(0, cap - 1);
    endcase
    voxel_at(x, y, z, $urandom_range(0, 65535) - 32768, ow,
             $urandom_range(0, 99) < 60, d);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.configure(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  logic [15:0] settings [6][8] = '{
    '{16'd8400, 16'd8400, 16'd5112, 16'd3832, 16'd1, 16'd1, 16'd640, 16'd480},
    '{16'd65535, 16'd65535, 16'd0, 16'd0, 16'd1000, 16'd255, 16'd4, 16'd4},
    '{16'd1200, 16'd900, 16'd600, 16'd500, 16'd0, 16'd0, 16'd80, 16'd60},
    '{16'd16, 16'd1, 16'd8000, 16'd65535, 16'd500, 16'd255, 16'd1023, 16'd480},
    '{16'd4000, 16'd4000, 16'd2000, 16'd1500, 16'd200, 16'd50, 16'd256, 16'd192},
    '{16'd8400, 16'd8400, 16'd5112, 16'd3832, 16'd20, 16'd100, 16'd640, 16'd480}
  };

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // centre pixel, band edges, skip reasons, extremes
    voxel_at(0, 0, 1000, 0, 0, 1, 1000);
    voxel_at(0, 0, 1020, 1000, 3, 0, 0);
    voxel_at(0, 0, 980, -1000, 7, 0, 0);
    voxel_at(0, 0, 1000, 5, 2, 1, 1021);
    voxel_at(0, 0, 1000, 5, 2, 1, 0);
    voxel_at(0, 0, 1000, 5, 100, 1, 1000);
    voxel_at(0, 0, 1000, 5, 255, 0, 0);
    voxel_at(0, 0, 990, 32767, 254, 0, 0);
    voxel_at(0, 0, 1010, -32768, 1, 0, 0);
    voxel_at(0, 0, 0, 1, 1, 0, 0);
    voxel_at(0, 0, -32768, 1, 1, 0, 0);
    voxel_at(32767, 0, 1, 0, 0, 0, 0);
    voxel_at(-32768, 32767, 1, 0, 0, 0, 0);
    voxel_at(0, 0, 32767, 0, 0, 1, 32767);
    voxel_at(-3000, -2000, 1000, 0, 0, 1, 1000);
    write_depth(524287, 65535);
    write_depth(STORE_SIZE, 1);
    write_depth(0, 65535);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        drain();
        for (int r = 0; r < 8; r++) write_reg(cfg_idx_t'(r), settings[ph - 1][r]);
      end
      for (int n = 0; n < 130; n++) begin
        random_voxel();
        if (sent > 1120) begin
          send_idle = 0;
          recv_idle = 0;
        end else if (sent > 560) begin
          send_idle = 45;
          recv_idle = 14;
        end
      end
    end

    drain();
    if (board.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
